@@ hdl/lpr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpr_pkg
// shared widths, reset values and controller/datapath interface types for the
// lru page replacement block
// ----------------------------------------------------------------------------
package lpr_pkg;

    // fixed port and stamp widths
    localparam int unsigned PAGE_NUM_W  = 16;
    localparam int unsigned FRAME_IDX_W = 3;
    localparam int unsigned TOTAL_W     = 32;
    localparam int unsigned STAMP_W     = 32;
    localparam int unsigned CFG_W       = 4;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;    // latch page, clear scan results
        logic issue;   // read the frame at the scan index
        logic update;  // commit frame table and counters, emit result
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;  // scan index is the last active frame
    } t_dp_stat;

    function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
        return (v == TOTAL_MAX) ? v : v + 1'b1;
    endfunction

endpackage

@@ hdl/lpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpr_ctrl
// sequencer for one page reference: accept, scan frames, drain, update
// ----------------------------------------------------------------------------
module lpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  lpr_pkg::t_dp_stat i_stat,
    output lpr_pkg::t_dp_cmd  o_cmd
);

    lpr_pkg::t_state r_state;
    lpr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            lpr_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = lpr_pkg::ST_SCAN;
                end
            end
            lpr_pkg::ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = lpr_pkg::ST_DRAIN;
                end
            end
            lpr_pkg::ST_DRAIN: begin
                // last read data is evaluated here
                n_state = lpr_pkg::ST_UPDATE;
            end
            lpr_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = lpr_pkg::ST_IDLE;
            end
            default: begin
                n_state = lpr_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (r_state != lpr_pkg::ST_IDLE);

endmodule

@@ hdl/lpr_datapath.sv @@
// ----------------------------------------------------------------------------
// lpr_datapath
// frame table memory, valid bits, scan evaluation, counters and result
// registers
// ----------------------------------------------------------------------------
module lpr_datapath #(
    parameter int unsigned MAX_FRAMES = 8,
    parameter int unsigned PAGE_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lpr_pkg::t_dp_cmd                     i_cmd,
    output lpr_pkg::t_dp_stat                    o_stat,
    input  logic [lpr_pkg::PAGE_NUM_W-1:0]       i_page_number,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]            i_cfg_data,
    output logic                                 o_valid,
    output logic                                 o_hit,
    output logic [lpr_pkg::FRAME_IDX_W-1:0]      o_frame_index,
    output logic                                 o_evicted_valid,
    output logic [lpr_pkg::PAGE_NUM_W-1:0]       o_evicted_page,
    output logic [lpr_pkg::TOTAL_W-1:0]          o_fault_total,
    output logic [lpr_pkg::TOTAL_W-1:0]          o_hit_total
);

    localparam int unsigned IW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int unsigned PW  = (PAGE_WIDTH < lpr_pkg::PAGE_NUM_W) ?
                                  PAGE_WIDTH : lpr_pkg::PAGE_NUM_W;
    localparam int unsigned SW  = lpr_pkg::STAMP_W;
    localparam int unsigned MW  = PW + SW;

    // frame table: {page, stamp}, read for every active frame; valid bits qualify it
    logic [MW-1:0]          r_mem [MAX_FRAMES];
    logic [MW-1:0]          r_rd_q;
    logic [MAX_FRAMES-1:0]  r_valid;

    logic [lpr_pkg::CFG_W-1:0] r_cfg;
    logic [IW-1:0]             k_m1;

    logic [PW-1:0]  r_page;
    logic [IW-1:0]  r_rd_idx;
    logic           r_dv;
    logic [IW-1:0]  r_didx;

    logic           r_found;
    logic [IW-1:0]  r_hit_idx;
    logic           r_empty;
    logic [IW-1:0]  r_empty_idx;
    logic [IW-1:0]  r_best_idx;
    logic [SW-1:0]  r_best_stamp;
    logic [PW-1:0]  r_best_page;

    logic [SW-1:0]                r_use;
    logic [lpr_pkg::TOTAL_W-1:0]  r_fault_cnt;
    logic [lpr_pkg::TOTAL_W-1:0]  r_hit_cnt;
    logic [SW-1:0]                n_use;

    logic [PW-1:0]  q_page;
    logic [SW-1:0]  q_stamp;
    logic           q_vld;
    logic [IW-1:0]  slot;
    logic           evict;

    // active frame count minus one, clamped to the table
    always_comb begin
        if (r_cfg == '0) begin
            k_m1 = '0;
        end else if (32'(r_cfg) > MAX_FRAMES) begin
            k_m1 = IW'(MAX_FRAMES - 1);
        end else begin
            k_m1 = IW'(r_cfg - 1'b1);
        end
    end

    assign o_stat.scan_last = (r_rd_idx == k_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lpr_pkg::CFG_RESET;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    // memory read and write ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_q <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[slot] <= {r_page, n_use};
        end
    end

    assign q_page  = r_rd_q[MW-1:SW];
    assign q_stamp = r_rd_q[SW-1:0];
    assign q_vld   = r_valid[r_didx];

    // scan index and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else begin
            r_dv <= i_cmd.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_page   <= PW'(i_page_number);
            r_rd_idx <= '0;
        end else if (i_cmd.issue) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        if (i_cmd.issue) begin
            r_didx <= r_rd_idx;
        end
    end

    // scan evaluation: first hit, first empty, first smallest stamp
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_found <= 1'b0;
            r_empty <= 1'b0;
        end else if (r_dv) begin
            if (q_vld && (q_page == r_page) && !r_found) begin
                r_found   <= 1'b1;
                r_hit_idx <= r_didx;
            end
            if (!q_vld && !r_empty) begin
                r_empty     <= 1'b1;
                r_empty_idx <= r_didx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv && ((r_didx == '0) || (q_stamp < r_best_stamp))) begin
            r_best_idx   <= r_didx;
            r_best_stamp <= q_stamp;
            r_best_page  <= q_page;
        end
    end

    always_comb begin
        if (r_found) begin
            slot = r_hit_idx;
        end else if (r_empty) begin
            slot = r_empty_idx;
        end else begin
            slot = r_best_idx;
        end
    end

    assign evict = !r_found && !r_empty;
    assign n_use = lpr_pkg::sat_inc(r_use);

    // table state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_use       <= '0;
            r_fault_cnt <= '0;
            r_hit_cnt   <= '0;
        end else if (i_cmd.update) begin
            r_valid[slot] <= 1'b1;
            r_use         <= n_use;
            if (r_found) begin
                r_hit_cnt <= lpr_pkg::sat_inc(r_hit_cnt);
            end else begin
                r_fault_cnt <= lpr_pkg::sat_inc(r_fault_cnt);
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.update;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            o_hit           <= r_found;
            o_frame_index   <= lpr_pkg::FRAME_IDX_W'(slot);
            o_evicted_valid <= evict;
            o_evicted_page  <= evict ? lpr_pkg::PAGE_NUM_W'(r_best_page) : '0;
        end
    end

    assign o_fault_total = r_fault_cnt;
    assign o_hit_total   = r_hit_cnt;

endmodule

@@ hdl/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement
// least-recently-used page replacement over a small frame table
// ----------------------------------------------------------------------------
// one page reference per transaction, started with start while busy is low.
// the block scans the active frames one per cycle out of a frame memory; the
// active frame count is frames_in_use clamped to 1..MAX_FRAMES, three by
// default. a reference goes through a read of each active frame, a drain state
// that evaluates the last read, an update state that commits, and the result
// on the ports. the result is shown for exactly one cycle with o_valid and
// cannot be held off, so the receiver must take it then; a new reference may be
// started in that same cycle. the frame count register is written over the cfg
// channel while busy is low.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int unsigned MAX_FRAMES = 8,
    parameter int unsigned PAGE_WIDTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // reference transaction
    input  logic                             start,
    output logic                             busy,
    input  logic [lpr_pkg::PAGE_NUM_W-1:0]   i_page_number,
    // configuration write: frames_in_use
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lpr_pkg::CFG_W-1:0]        i_cfg_data,
    // result, one cycle strobe
    output logic                             o_valid,
    output logic                             o_hit,
    output logic [lpr_pkg::FRAME_IDX_W-1:0]  o_frame_index,
    output logic                             o_evicted_valid,
    output logic [lpr_pkg::PAGE_NUM_W-1:0]   o_evicted_page,
    output logic [lpr_pkg::TOTAL_W-1:0]      o_fault_total,
    output logic [lpr_pkg::TOTAL_W-1:0]      o_hit_total
);

    lpr_pkg::t_dp_cmd  dp_cmd;
    lpr_pkg::t_dp_stat dp_stat;

    // config only lands between transactions
    assign o_cfg_ready = !busy;

    // sequencer: idle -> scan (one read per active frame) -> drain -> update
    lpr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // frame memory, valid bits, lookup and victim search, totals
    lpr_datapath #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_WIDTH (PAGE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_stat          (dp_stat),
        .i_page_number   (i_page_number),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total),
        .o_hit_total     (o_hit_total)
    );

endmodule

@@ hdl/lpr_checker.sv @@
// ----------------------------------------------------------------------------
// lpr_checker
// port-level checks for the lru page replacement block
// ----------------------------------------------------------------------------
module lpr_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid,
    input logic                             o_hit,
    input logic                             o_evicted_valid,
    input logic [lpr_pkg::PAGE_NUM_W-1:0]   o_evicted_page
);

    // a result only comes out once the scan is done
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // an accepted reference occupies the block
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("not busy after accept");

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_hit) |-> (!o_evicted_valid && (o_evicted_page == '0)))
        else $error("eviction reported on a hit");

    // one strobe per transaction
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_hit           (o_hit),
    .o_evicted_valid (o_evicted_valid),
    .o_evicted_page  (o_evicted_page)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the lru page replacement block: drives page
// references and frame count writes, predicts every result with its own copy
// of the frame table, and compares each result field by field
// ----------------------------------------------------------------------------
module testbench;

    // cycles with no transaction of any kind before the run is given up
    localparam int unsigned STALL_LIMIT = 2000;
    // settle time for the final drain, longer than the longest reference
    localparam int unsigned SETTLE_CYCLES = 24;
    localparam int unsigned TABLE_DEPTH = 8;
    localparam int unsigned PHASE_REFS = 145;
    localparam int unsigned NUM_PHASES = 12;

    // one result as it shows on the output ports
    typedef struct packed {
        logic                            hit;
        logic [lpr_pkg::FRAME_IDX_W-1:0] frame;
        logic                            evicted;
        logic [lpr_pkg::PAGE_NUM_W-1:0]  evicted_page;
        logic [lpr_pkg::TOTAL_W-1:0]     faults;
        logic [lpr_pkg::TOTAL_W-1:0]     hits;
    } t_lookup_result;

    // ------------------------------------------------------------------------
    // frame table predictor and result queue
    // ------------------------------------------------------------------------
    class page_table_sb;
        logic [lpr_pkg::CFG_W-1:0]      frames_reg;
        bit                             slot_valid [TABLE_DEPTH];
        logic [lpr_pkg::PAGE_NUM_W-1:0] slot_page  [TABLE_DEPTH];
        logic [lpr_pkg::STAMP_W-1:0]    slot_stamp [TABLE_DEPTH];
        logic [lpr_pkg::STAMP_W-1:0]    use_cnt;
        logic [lpr_pkg::TOTAL_W-1:0]    fault_cnt;
        logic [lpr_pkg::TOTAL_W-1:0]    hit_cnt;
        t_lookup_result                 pending[$];
        int                             n_errors;
        int                             n_checked;
        int                             n_hits;
        int                             n_evictions;
        int                             n_cfg_writes;

        function new();
            frames_reg = lpr_pkg::CFG_RESET;
            use_cnt    = '0;
            fault_cnt  = '0;
            hit_cnt    = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_valid[i] = 1'b0;
                slot_page[i]  = '0;
                slot_stamp[i] = '0;
            end
        endfunction

        function void set_frames(logic [lpr_pkg::CFG_W-1:0] value);
            frames_reg = value;
            n_cfg_writes++;
        endfunction

        // accepted reference: work out its result and update the table
        function void note_ref(logic [lpr_pkg::PAGE_NUM_W-1:0] page);
            int                          active;
            int                          slot;
            bit                          found;
            bit                          have_empty;
            logic [lpr_pkg::STAMP_W-1:0] oldest;
            t_lookup_result              r;

            // zero behaves as one frame, anything above the table as all of it
            active = (frames_reg == 0) ? 1 :
                     (frames_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(frames_reg);
            found = 1'b0;
            have_empty = 1'b0;
            slot = 0;
            r = '0;

            // lowest active frame holding the page wins on duplicates
            for (int i = 0; i < active && !found; i++) begin
                if (slot_valid[i] && slot_page[i] == page) begin
                    found = 1'b1;
                    slot = i;
                end
            end

            if (found) begin
                if (hit_cnt != '1) hit_cnt++;
            end else begin
                for (int i = 0; i < active && !have_empty; i++) begin
                    if (!slot_valid[i]) begin
                        have_empty = 1'b1;
                        slot = i;
                    end
                end
                if (!have_empty) begin
                    // strict less-than keeps the lowest frame on a stamp tie
                    oldest = slot_stamp[0];
                    slot = 0;
                    for (int i = 1; i < active; i++) begin
                        if (slot_stamp[i] < oldest) begin
                            oldest = slot_stamp[i];
                            slot = i;
                        end
                    end
                    r.evicted = 1'b1;
                    r.evicted_page = slot_page[slot];
                end
                slot_valid[slot] = 1'b1;
                slot_page[slot] = page;
                if (fault_cnt != '1) fault_cnt++;
            end

            if (use_cnt != '1) use_cnt++;
            slot_stamp[slot] = use_cnt;

            r.hit    = found;
            r.frame  = slot[lpr_pkg::FRAME_IDX_W-1:0];
            r.faults = fault_cnt;
            r.hits   = hit_cnt;
            pending.push_back(r);
        endfunction

        task report_mismatch(string what, logic [lpr_pkg::TOTAL_W-1:0] got,
                             logic [lpr_pkg::TOTAL_W-1:0] want);
            $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
            n_errors++;
        endtask

        task compare_field(string name, logic [lpr_pkg::TOTAL_W-1:0] got,
                           logic [lpr_pkg::TOTAL_W-1:0] want);
            if (got !== want) report_mismatch(name, got, want);
        endtask

        task check_result(t_lookup_result got);
            t_lookup_result want;
            if (pending.size() == 0) begin
                report_mismatch("result with nothing outstanding", 32'(got.frame), '0);
            end else begin
                want = pending.pop_front();
                n_checked++;
                if (want.hit) n_hits++;
                if (want.evicted) n_evictions++;
                compare_field("hit", 32'(got.hit), 32'(want.hit));
                compare_field("frame_index", 32'(got.frame), 32'(want.frame));
                compare_field("evicted_valid", 32'(got.evicted), 32'(want.evicted));
                compare_field("evicted_page", 32'(got.evicted_page),
                              32'(want.evicted_page));
                compare_field("fault_total", got.faults, want.faults);
                compare_field("hit_total", got.hits, want.hits);
            end
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and dut
    // ------------------------------------------------------------------------
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [lpr_pkg::PAGE_NUM_W-1:0]  i_page_number = '0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [lpr_pkg::CFG_W-1:0]       i_cfg_data = '0;
    logic                            o_valid;
    logic                            o_hit;
    logic [lpr_pkg::FRAME_IDX_W-1:0] o_frame_index;
    logic                            o_evicted_valid;
    logic [lpr_pkg::PAGE_NUM_W-1:0]  o_evicted_page;
    logic [lpr_pkg::TOTAL_W-1:0]     o_fault_total;
    logic [lpr_pkg::TOTAL_W-1:0]     o_hit_total;

    page_table_sb sb;
    int unsigned  idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    lru_page_replacement u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total),
        .o_hit_total     (o_hit_total)
    );

    // ------------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge, where the values
    // seen are the ones from before the edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lookup_result got;
        bit             moved;
        moved = 1'b0;
        if (i_rst_n) begin
            // reference transaction
            if (start && !busy) begin
                sb.note_ref(i_page_number);
                moved = 1'b1;
            end
            // frame count write
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_frames(i_cfg_data);
                moved = 1'b1;
            end
            // result strobe, cannot be held off so it is taken every time
            if (o_valid) begin
                got.hit          = o_hit;
                got.frame        = o_frame_index;
                got.evicted      = o_evicted_valid;
                got.evicted_page = o_evicted_page;
                got.faults       = o_fault_total;
                got.hits         = o_hit_total;
                sb.check_result(got);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // watchdog: ends the run once nothing has moved for too long
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers: inputs only change on the falling edge
    // ------------------------------------------------------------------------

    // one page reference, preceded by gap cycles with start low
    task send_ref(input logic [lpr_pkg::PAGE_NUM_W-1:0] page, input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_page_number = page;
        do @(posedge i_clk); while (busy);
    endtask

    // stop issuing and wait for every outstanding result
    task wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        i_page_number = lpr_pkg::PAGE_NUM_W'($urandom);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    // frame count write, only once the block has gone quiet
    task write_frames(input logic [lpr_pkg::CFG_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = lpr_pkg::CFG_W'($urandom);
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        logic [lpr_pkg::PAGE_NUM_W-1:0] hot_pages [12];
        logic [lpr_pkg::CFG_W-1:0]      frames;
        logic [lpr_pkg::PAGE_NUM_W-1:0] page;
        int                             hot_count;
        bit                             back_to_back;
        int                             gap;

        sb = new();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part, default of three frames first:
        // fill frames 0 and 1, hit frame 0, fill frame 2, then two evictions
        // that each take the least recently used frame
        send_ref(16'h0000, 0);
        send_ref(16'hFFFF, 1);
        send_ref(16'h0000, 0);
        send_ref(16'h5555, 2);
        send_ref(16'hAAAA, 0);
        send_ref(16'hFFFF, 0);

        // zero frames acts as one: frame 0 is replaced every miss
        write_frames(4'd0);
        send_ref(16'h1234, 0);
        send_ref(16'h1234, 3);
        send_ref(16'h8001, 0);

        // above the table acts as all eight frames; frames outside the old
        // range kept their pages, so 0xaaaa in frame 1 hits again
        write_frames(4'd15);
        send_ref(16'hAAAA, 0);
        send_ref(16'h0101, 0);
        send_ref(16'h0202, 0);
        send_ref(16'h0404, 0);
        send_ref(16'h0808, 0);
        send_ref(16'h1010, 0);
        send_ref(16'h2020, 0);

        // duplicate residents: put 0xaaaa into frame 0 as well, then widen
        // the range so frames 0 and 1 both hold it; the lower one is hit
        write_frames(4'd1);
        send_ref(16'hAAAA, 0);
        write_frames(4'd8);
        send_ref(16'hAAAA, 0);
        send_ref(16'h7FFF, 0);
        send_ref(16'h8000, 0);

        // random part: each phase picks a frame count and a small set of hot
        // pages so that hits, fills and evictions all happen often
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: frames = 4'd1;
                1: frames = 4'd8;
                2: frames = 4'd0;
                3: frames = 4'd15;
                4: frames = lpr_pkg::CFG_RESET;
                5: frames = 4'd9;
                default: frames = lpr_pkg::CFG_W'($urandom_range(0, 15));
            endcase
            write_frames(frames);

            hot_count = $urandom_range(1, 12);
            for (int i = 0; i < hot_count; i++) begin
                hot_pages[i] = lpr_pkg::PAGE_NUM_W'($urandom);
            end
            // some phases run with no gaps at all
            back_to_back = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_REFS; n++) begin
                if ($urandom_range(0, 9) < 7)
                    page = hot_pages[$urandom_range(0, hot_count - 1)];
                else
                    page = lpr_pkg::PAGE_NUM_W'($urandom);
                gap = back_to_back ? 0 : $urandom_range(0, 10);

                // hold off until the block is empty, once for sure and now
                // and then at random
                if ((ph == 5 && n == 70) || $urandom_range(0, 199) == 0)
                    wait_drained();
                send_ref(page, gap);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        // anything still queued means a result never showed up
        while (sb.pending.size() != 0) begin
            void'(sb.pending.pop_front());
            sb.report_mismatch("result never arrived", '0, '0);
        end

        $display("summary: %0d references checked, %0d hits, %0d evictions",
                 sb.n_checked, sb.n_hits, sb.n_evictions);
        $display("summary: %0d frame count writes across %0d random phases, %0d errors",
                 sb.n_cfg_writes, NUM_PHASES, sb.n_errors);
        if (sb.n_errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
